[design/atid_pkg.sv]
package atid_pkg;

  localparam int TBL_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int FIELD_W   = 5;

  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_DELETE_AT     = 3'd2,
    OP_DELETE_FIRST  = 3'd3,
    OP_DELETE_ALL    = 3'd4,
    OP_READ          = 3'd5
  } op_t;

  typedef struct packed {
    op_t                       opcode;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic [FIELD_W-1:0]        fill_count;
    logic [FIELD_W-1:0]        removed;
    logic signed [DATA_W-1:0]  read_data;
  } rsp_t;

  typedef enum logic [1:0] {
    TGT_POS,
    TGT_SORT,
    TGT_MATCH
  } tgt_kind_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE
  } cell_act_t;

  typedef struct packed {
    tgt_kind_t          kind;
    cell_act_t          act;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

[design/array_table_insert_delete.sv]
// Channel   Handshake          Payload   Direction
// request   start / busy       req       in, taken when start && !busy
// result    done (one cycle)   rsp       out, no backpressure
//
// Each request is taken at the accept edge, then makes one pass of the cell
// chain in which all cells compare against the value, the first-target flag
// ripples down the row and every cell shifts or loads at once.
// Delete_all instead makes one pass per match, plus a last pass that finds none.
// The result shows on rsp with done high in the cycle after the last pass;
// busy is low then, so the next request may be taken in that cycle.
// rst clears the fill count and the control; the entries hold no reset.
module array_table_insert_delete
  import atid_pkg::*;
#(
  parameter int DEPTH = TBL_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t            state;
  req_t              cur;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rem_cnt;

  cell_ctrl_t        ctrl;
  logic              pos_ok;
  logic [DATA_W-1:0] data   [DEPTH];
  logic              hit    [DEPTH];
  logic              live   [DEPTH];
  logic              pos_hit[DEPTH];
  logic              seen   [DEPTH+1];
  logic              found;

  logic [IW-1:0]     posx;
  logic [IW-1:0]     cntx;
  logic [IW-1:0]     pos_idx;
  logic              ins_ok;
  logic              del_ok;
  logic              full;
  logic [DATA_W-1:0] rd_sel;

  logic              fin;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     rem_next;
  rsp_t              rsp_next;

  assign busy    = (state == S_RUN);
  assign posx    = IW'(cur.position);
  assign cntx    = IW'(count);
  assign pos_idx = posx - IW'(1);
  assign ins_ok  = (posx != '0) && (posx <= cntx + IW'(1)) && (posx <= IW'(DEPTH));
  assign del_ok  = (posx != '0) && (posx <= cntx);
  assign full    = (count == CW'(DEPTH));

  assign seen[0] = 1'b0;
  assign found   = seen[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    assign live[i]    = (count > CW'(i));
    assign pos_hit[i] = pos_ok && (pos_idx == IW'(i));

    if (i == 0) begin : g_first
      assign left_d = data[i];
    end else begin : g_mid
      assign left_d = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = data[i];
    end else begin : g_body
      assign right_d = data[i+1];
    end

    atid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (live[i]),
      .pos_hit   (pos_hit[i]),
      .seen_in   (seen[i]),
      .left_data (left_d),
      .right_data(right_d),
      .data      (data[i]),
      .hit       (hit[i]),
      .seen_out  (seen[i+1])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_sel = rd_sel | (hit[i] ? data[i] : '0);
    end
  end

  always_comb begin
    ctrl.kind  = TGT_POS;
    ctrl.act   = ACT_HOLD;
    ctrl.value = cur.value;
    pos_ok     = 1'b0;
    if (state == S_RUN) begin
      case (cur.opcode)
        OP_INSERT_AT: begin
          pos_ok   = ins_ok;
          ctrl.act = ACT_INSERT;
        end
        OP_INSERT_SORTED: begin
          ctrl.kind = TGT_SORT;
          ctrl.act  = ACT_INSERT;
        end
        OP_DELETE_AT: begin
          pos_ok   = del_ok;
          ctrl.act = ACT_DELETE;
        end
        OP_DELETE_FIRST, OP_DELETE_ALL: begin
          ctrl.kind = TGT_MATCH;
          ctrl.act  = ACT_DELETE;
        end
        OP_READ: begin
          pos_ok = del_ok;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fin        = 1'b1;
    count_next = count;
    rem_next   = rem_cnt;
    rsp_next   = '0;
    case (cur.opcode)
      OP_INSERT_AT: begin
        if (ins_ok) begin
          rsp_next.ok = 1'b1;
          if (full) begin
            rsp_next.removed = FIELD_W'(1);
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      OP_INSERT_SORTED: begin
        rsp_next.ok = 1'b1;
        if (found) begin
          if (full) begin
            rsp_next.removed = FIELD_W'(1);
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      OP_DELETE_AT, OP_DELETE_FIRST: begin
        if ((cur.opcode == OP_DELETE_AT) ? del_ok : found) begin
          rsp_next.ok      = 1'b1;
          rsp_next.removed = FIELD_W'(1);
          count_next       = count - CW'(1);
        end
      end
      OP_DELETE_ALL: begin
        if (found) begin
          fin        = 1'b0;
          count_next = count - CW'(1);
          rem_next   = rem_cnt + CW'(1);
        end else begin
          rsp_next.ok      = 1'b1;
          rsp_next.removed = FIELD_W'(rem_cnt);
        end
      end
      OP_READ: begin
        rsp_next.ok        = del_ok;
        rsp_next.read_data = rd_sel;
      end
      default: ;
    endcase
    rsp_next.fill_count = FIELD_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rem_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur     <= req;
            rem_cnt <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          count   <= count_next;
          rem_cnt <= rem_next;
          if (fin) begin
            rsp   <= rsp_next;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/atid_cell.sv]
module atid_cell
  import atid_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              live,
  input  logic              pos_hit,
  input  logic              seen_in,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              hit,
  output logic              seen_out
);

  logic lt;
  logic eq;

  assign lt = $signed(data) < $signed(ctrl.value);
  assign eq = (data == ctrl.value);

  always_comb begin
    case (ctrl.kind)
      TGT_POS:   hit = pos_hit;
      TGT_SORT:  hit = !seen_in && !(live && lt);
      TGT_MATCH: hit = !seen_in && live && eq;
      default:   hit = 1'b0;
    endcase
  end

  assign seen_out = seen_in || hit;

  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_INSERT: begin
        if (hit) begin
          data <= ctrl.value;
        end else if (seen_in) begin
          data <= left_data;
        end
      end
      ACT_DELETE: begin
        if (hit || seen_in) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/atid_checker.sv]
module atid_checker
  import atid_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in work");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.removed != '0)) |-> rsp.ok)
    else $error("entries removed by a failed transaction");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.read_data != '0)) |-> rsp.ok)
    else $error("read data on a failed transaction");

endmodule

bind array_table_insert_delete atid_checker u_atid_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

[test/atid_table_check.sv]
module atid_table_check
  import atid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  req_t               req,
  input  logic               done,
  input  rsp_t               rsp,
  output int                 n_errors,
  output int                 n_waiting,
  output logic [FIELD_W-1:0] level
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DATA_W-1:0] cells [TBL_DEPTH];
  int                       live;
  rsp_t                     waiting_q [$];

  function automatic int shift_in(int idx, logic signed [DATA_W-1:0] v);
    int top;
    int dropped;
    top = live;
    dropped = 0;
    if (live >= TBL_DEPTH) begin
      top = TBL_DEPTH - 1;
      dropped = 1;
    end
    for (int i = top; i > idx; i--) cells[i] = cells[i-1];
    cells[idx] = v;
    if (live < TBL_DEPTH) live++;
    return dropped;
  endfunction

  function automatic void remove_at(int idx);
    for (int i = idx; i + 1 < live; i++) cells[i] = cells[i+1];
    live--;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   pos;
    int   i;
    int   kept;
    pos = int'(r.position);
    res = '0;
    case (r.opcode)
      OP_INSERT_AT: begin
        if (pos >= 1 && pos <= live + 1 && pos <= TBL_DEPTH) begin
          res.removed = FIELD_W'(shift_in(pos - 1, r.value));
          res.ok = 1'b1;
        end
      end
      OP_INSERT_SORTED: begin
        i = 0;
        while (i < live && cells[i] < r.value) i++;
        if (i < TBL_DEPTH) res.removed = FIELD_W'(shift_in(i, r.value));
        res.ok = 1'b1;
      end
      OP_DELETE_AT: begin
        if (pos >= 1 && pos <= live) begin
          remove_at(pos - 1);
          res.removed = FIELD_W'(1);
          res.ok = 1'b1;
        end
      end
      OP_DELETE_FIRST: begin
        for (i = 0; i < live; i++) begin
          if (cells[i] == r.value) begin
            remove_at(i);
            res.removed = FIELD_W'(1);
            res.ok = 1'b1;
            break;
          end
        end
      end
      OP_DELETE_ALL: begin
        kept = 0;
        for (i = 0; i < live; i++) begin
          if (cells[i] != r.value) begin
            cells[kept] = cells[i];
            kept++;
          end else begin
            res.removed = res.removed + 1'b1;
          end
        end
        live = kept;
        res.ok = 1'b1;
      end
      OP_READ: begin
        if (pos >= 1 && pos <= live) begin
          res.read_data = cells[pos - 1];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.fill_count = FIELD_W'(live);
    return res;
  endfunction

  initial begin
    n_errors = 0;
    n_waiting = 0;
    level = '0;
    live = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      live = 0;
      waiting_q.delete();
    end else begin
      if (done) begin
        if (waiting_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errs++;
        end else begin
          want = waiting_q.pop_front();
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0d actual %0d", want.ok, rsp.ok);
            errs++;
          end
          if (rsp.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d actual %0d", want.fill_count, rsp.fill_count);
            errs++;
          end
          if (rsp.removed !== want.removed) begin
            $error("removed: expected %0d actual %0d", want.removed, rsp.removed);
            errs++;
          end
          if (rsp.read_data !== want.read_data) begin
            $error("read_data: expected %0d actual %0d", want.read_data, rsp.read_data);
            errs++;
          end
        end
      end
      if (start && !busy) waiting_q.push_back(apply_request(req));
    end
    n_errors <= n_errors + errs;
    n_waiting <= waiting_q.size();
    level <= FIELD_W'(live);
  end

endmodule

[test/tb.sv]
module tb;
  import atid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_ITEMS = 1900;
  localparam int   STALL_LIMIT  = 2000;
  localparam op_t  OP_UNDEF_A   = op_t'(3'd6);
  localparam op_t  OP_UNDEF_B   = op_t'(3'd7);

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               done;
  rsp_t               rsp;
  int                 n_errors;
  int                 n_waiting;
  logic [FIELD_W-1:0] level;

  array_table_insert_delete dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  atid_table_check u_check (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .n_errors (n_errors),
    .n_waiting(n_waiting),
    .level    (level)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic issue(input op_t op, input int pos, input logic signed [DATA_W-1:0] val);
    start <= 1'b1;
    req <= '{opcode: op, position: POS_W'(pos), value: val};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (n_waiting != 0) @(negedge clk);
  endtask

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stalled = 0;
      else stalled++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    op_t                      op;
    int                       pos;
    int                       roll;
    logic signed [DATA_W-1:0] val;
    bit                       draining;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: every position and match misses; then the table is filled to its depth
    issue(OP_READ, 1, 0);
    issue(OP_DELETE_AT, 1, 0);
    issue(OP_DELETE_FIRST, 0, 0);
    issue(OP_DELETE_ALL, 0, 0);
    issue(OP_INSERT_AT, 2, 5);
    issue(OP_UNDEF_B, 1, -1);
    issue(OP_INSERT_AT, 1, 1000);
    issue(OP_INSERT_SORTED, 0, 32'sh8000_0000);
    for (int i = 0; i < 14; i++) issue(OP_INSERT_SORTED, 0, 7);
    // full table: oversized sorted value is discarded, tail drops on insert
    issue(OP_INSERT_SORTED, 0, 32'sh7fff_ffff);
    issue(OP_INSERT_AT, 17, 3);
    issue(OP_INSERT_AT, 16, -5);
    issue(OP_READ, 16, 0);
    issue(OP_DELETE_FIRST, 0, 7);
    issue(OP_DELETE_ALL, 0, 7);
    issue(OP_DELETE_AT, 1, 0);
    settle();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      draining = ((k / 150) % 2) == 1;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        op = $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
      end else if (roll < 14) begin
        op = OP_READ;
      end else if (roll < (draining ? 44 : 74)) begin
        op = $urandom_range(0, 1) ? OP_INSERT_AT : OP_INSERT_SORTED;
      end else begin
        case ($urandom_range(0, 3))
          0, 1: op = OP_DELETE_AT;
          2: op = OP_DELETE_FIRST;
          default: op = OP_DELETE_ALL;
        endcase
      end

      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        val = int'($urandom_range(0, 4)) - 2;
      end else if (roll < 6) begin
        case ($urandom_range(0, 3))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7fff_ffff;
          2: val = -1;
          default: val = 0;
        endcase
      end else begin
        val = $urandom;
      end

      if ($urandom_range(0, 3) != 0) pos = $urandom_range(1, int'(level) + 1);
      else pos = $urandom_range(0, 31);

      issue(op, pos, val);
      if (k == RANDOM_ITEMS / 2) settle();
      else if (k < RANDOM_ITEMS - 300 && (k < 500 || k > 650) && $urandom_range(0, 3) == 0)
        rest($urandom_range(1, 15));
    end

    settle();
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
